/* rtl/rtnr_pkg.sv */
// Package for the reciprocal unit: table geometry, pipeline sideband type,
// register map. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rtnr_pkg;
	localparam int INDEX_WIDTH  = 7;
	localparam int MAX_STEPS    = 2;
	localparam int TABLE_DEPTH  = 1 << INDEX_WIDTH;
	localparam int OFFSET_BITS  = 31 - INDEX_WIDTH;
	localparam int SLOPE_SHIFT  = 14;
	localparam int PROD_W       = OFFSET_BITS + 18;
	localparam int Q_W          = PROD_W - SLOPE_SHIFT;

	localparam logic [2:0] REG_LIMIT_ADDR = 3'd0;
	localparam logic       ACT_WRITE      = 1'b0;
	localparam logic       ACT_COMPUTE    = 1'b1;

	// Control that rides alongside each reciprocal through the pipeline
	typedef struct packed {
		logic        valid;
		logic        extra;
		logic [31:0] d;
	} side_t;
endpackage
`default_nettype wire

/* rtl/rtnr_refine.sv */
// One Newton-Raphson refinement step, four register stages.
// Depends on rtnr_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rtnr_refine
	import rtnr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        apply,
	input  wire side_t       side_in,
	input  wire logic [63:0] r_in,
	output side_t            side_out,
	output logic      [63:0] r_out
);
	side_t       side_s1, side_s2, side_s3;
	logic        apply_s1, apply_s2, apply_s3;
	logic [63:0] r_s1, r_s2, r_s3;
	logic [63:0] pl_s1, ph_s1;
	logic [63:0] diff_s2;
	logic        nz_s2;
	logic        nz_s2_s3;
	logic [63:0] ll_s3, lh_s3, hl_s3, hh_s3;

	logic [95:0]  full;
	logic [63:0]  lo;
	logic [31:0]  hi;
	logic [63:0]  dh;
	logic         borrow;
	logic [32:0]  hb;
	logic [127:0] acc;
	logic [63:0]  stepped;

	always_comb begin
		full   = {ph_s1, 32'd0} + {32'd0, pl_s1};
		lo     = full[63:0];
		hi     = full[95:64];
		dh     = {33'd0, side_s1.d[31:1]};
		borrow = dh < lo;
		hb     = {1'b0, hi} + {32'd0, borrow};
		acc    = {64'd0, ll_s3} + {32'd0, lh_s3, 32'd0} + {32'd0, hl_s3, 32'd0}
			+ {hh_s3, 64'd0};
		stepped = acc[127:64] + (nz_s2_s3 ? r_s3 : 64'd0);
	end

	// valid bits reset; the data fields simply load whenever out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.valid  <= 1'b0;
			side_s2.valid  <= 1'b0;
			side_s3.valid  <= 1'b0;
			side_out.valid <= 1'b0;
		end else begin
			side_s1.valid  <= side_in.valid;
			side_s2.valid  <= side_s1.valid;
			side_s3.valid  <= side_s2.valid;
			side_out.valid <= side_s3.valid;

			side_s1.extra <= side_in.extra;
			side_s1.d     <= side_in.d;
			apply_s1      <= apply;
			r_s1          <= r_in;
			pl_s1         <= {32'd0, r_in[31:0]} * {32'd0, side_in.d};
			ph_s1         <= {32'd0, r_in[63:32]} * {32'd0, side_in.d};

			side_s2.extra <= side_s1.extra;
			side_s2.d     <= side_s1.d;
			apply_s2      <= apply_s1;
			r_s2          <= r_s1;
			diff_s2       <= dh - lo;
			nz_s2         <= hb != 33'd2;

			side_s3.extra <= side_s2.extra;
			side_s3.d     <= side_s2.d;
			apply_s3      <= apply_s2;
			r_s3          <= r_s2;
			nz_s2_s3      <= nz_s2;
			ll_s3         <= {32'd0, r_s2[31:0]}  * {32'd0, diff_s2[31:0]};
			lh_s3         <= {32'd0, r_s2[31:0]}  * {32'd0, diff_s2[63:32]};
			hl_s3         <= {32'd0, r_s2[63:32]} * {32'd0, diff_s2[31:0]};
			hh_s3         <= {32'd0, r_s2[63:32]} * {32'd0, diff_s2[63:32]};

			side_out.extra <= side_s3.extra;
			side_out.d     <= side_s3.d;
			r_out          <= apply_s3 ? stepped : r_s3;
		end
	end
endmodule
`default_nettype wire

/* rtl/reciprocal_table_newton_raphson.sv */
// Top level of the table-seeded Newton-Raphson reciprocal unit.
// Depends on rtnr_pkg and rtnr_refine.
//
//   channel  | handshake          | payload
//   ---------+--------------------+---------------------------------------------
//   input    | start / busy       | action, entry_index, entry_base, slopes, divisor
//   result   | done (one cycle)   | reciprocal, bad_divisor
//   config   | APB psel/penable   | extra_step_limit at address 0
//
// One transaction per cycle; busy is always low. A result passes through
// the four-stage seed path and then four stages per refinement step.
// Table writes take effect in the seed stage, in order with lookups.
// Reset clears valid bits and sets extra_step_limit to all ones; the table
// is undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module reciprocal_table_newton_raphson
	import rtnr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [6:0]  entry_index,
	input  wire logic [31:0] entry_base,
	input  wire logic [15:0] entry_slope_low,
	input  wire logic [15:0] entry_slope_high,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      reciprocal,
	output logic             bad_divisor,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [31:0] limit_q;
	logic [63:0] table_mem [TABLE_DEPTH];

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic             act_s1;
	logic [INDEX_WIDTH-1:0] widx_s1;
	logic [63:0]      wdata_s1;
	logic [31:0]      d_s1, d_s2, d_s3, d_s4;
	logic             bad_s2, bad_s3, bad_s4;
	logic             ext_s2, ext_s3, ext_s4;
	logic [4:0]       shift_s2, shift_s3;
	logic [OFFSET_BITS-1:0] low_s2;
	logic [63:0]      entry_s2;
	logic [32:0]      r1_s3;
	logic signed [PROD_W-1:0] prod_s3;
	logic [63:0]      est_s4;

	logic [4:0]       top;
	logic [4:0]       shift;
	logic [31:0]      a1;
	logic signed [OFFSET_BITS:0] offset;
	logic [15:0]      slope;
	logic signed [Q_W-1:0] q;
	logic [63:0]      seed;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign prdata = (paddr == REG_LIMIT_ADDR) ? limit_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '1;
		end else if (psel && penable && pwrite && paddr == REG_LIMIT_ADDR) begin
			limit_q <= pwdata;
		end
	end

	always_comb begin
		top = 5'd0;
		for (int i = 1; i < 32; i++) begin
			if (d_s1[i]) begin
				top = 5'(i);
			end
		end
		shift  = 5'd31 - top;
		a1     = d_s1 << shift;
		offset = $signed({1'b0, low_s2}) - $signed((OFFSET_BITS + 1)'(1 << (OFFSET_BITS - 1)))
			+ $signed((OFFSET_BITS + 1)'(1));
		slope  = offset < 0 ? entry_s2[47:32] : entry_s2[63:48];
		q      = Q_W'(prod_s3 >>> SLOPE_SHIFT);
		seed   = ({31'd0, r1_s3} - 64'($signed(q))) << shift_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1 && act_s1 == ACT_COMPUTE;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			act_s1   <= action;
			widx_s1  <= INDEX_WIDTH'(entry_index);
			wdata_s1 <= {entry_slope_high, entry_slope_low, entry_base};
			d_s1     <= divisor;
		end
		// table write and lookup share the seed stage, so order is kept
		if (vld_s1 && act_s1 == ACT_WRITE) begin
			table_mem[widx_s1] <= wdata_s1;
		end
		entry_s2 <= table_mem[a1[30:OFFSET_BITS]];
		d_s2     <= d_s1;
		bad_s2   <= d_s1 < 32'd3;
		ext_s2   <= d_s1 <= limit_q;
		shift_s2 <= shift;
		low_s2   <= a1[OFFSET_BITS-1:0];

		d_s3     <= d_s2;
		bad_s3   <= bad_s2;
		ext_s3   <= ext_s2;
		shift_s3 <= shift_s2;
		r1_s3    <= {1'b1, entry_s2[31:0]};
		prod_s3  <= PROD_W'($signed({1'b0, slope}) * offset);

		d_s4     <= d_s3;
		bad_s4   <= bad_s3;
		ext_s4   <= ext_s3;
		est_s4   <= bad_s3 ? 64'd0 : seed;
	end

	// refinement of a zero seed stays zero, which covers small divisors
	side_t       side_c [MAX_STEPS+1];
	logic [63:0] r_c    [MAX_STEPS+1];
	logic        bad_d  [MAX_STEPS*4+1];

	assign side_c[0] = '{valid: vld_s4, extra: ext_s4, d: d_s4};
	assign r_c[0]    = est_s4;
	assign bad_d[0]  = bad_s4;

	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_step
		rtnr_refine u_refine (
			.clk     (clk),
			.arst_n  (arst_n),
			.apply   (k == 0 ? 1'b1 : side_c[k].extra),
			.side_in (side_c[k]),
			.r_in    (r_c[k]),
			.side_out(side_c[k+1]),
			.r_out   (r_c[k+1])
		);
	end

	for (genvar j = 0; j < MAX_STEPS*4; j++) begin : g_bad
		always_ff @(posedge clk) begin
			bad_d[j+1] <= bad_d[j];
		end
	end

	assign done        = side_c[MAX_STEPS].valid;
	assign reciprocal  = r_c[MAX_STEPS];
	assign bad_divisor = bad_d[MAX_STEPS*4];
endmodule
`default_nettype wire

/* verif/rtnr_checker.sv */
// Scoreboard for the reciprocal unit: follows table writes and limit writes,
// predicts each reciprocal and compares it with the done strobe.
// Depends on rtnr_pkg.
`timescale 1ns / 1ps
module rtnr_checker
	import rtnr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        busy,
	input  wire logic        action,
	input  wire logic [6:0]  entry_index,
	input  wire logic [31:0] entry_base,
	input  wire logic [15:0] entry_slope_low,
	input  wire logic [15:0] entry_slope_high,
	input  wire logic [31:0] divisor,
	input  wire logic        done,
	input  wire logic [63:0] reciprocal,
	input  wire logic        bad_divisor,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	input  wire logic        pready,
	output int               mismatches,
	output int               outstanding,
	output int               checked
);
	typedef struct {
		logic [63:0] recip;
		logic        bad;
	} recip_t;

	logic [63:0] coeffs [TABLE_DEPTH];
	logic [31:0] step_limit;
	recip_t      pending_recips[$];

	initial begin
		mismatches = 0;
		checked = 0;
	end

	assign outstanding = pending_recips.size();

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [63:0] mul_hi(input logic [63:0] x, input logic [63:0] y,
			output logic [63:0] lo);
		logic [127:0] p;
		p = {64'd0, x} * {64'd0, y};
		lo = p[63:0];
		return p[127:64];
	endfunction

	// One Newton-Raphson step with the half-ULP rounding term folded in
	function automatic logic [63:0] nr_step(input logic [63:0] r, input logic [63:0] d);
		logic [63:0] lo, hi, diff, hi2, unused;
		logic        borrow;
		hi = mul_hi(r, d, lo);
		diff = (d >> 1) - lo;
		borrow = (d >> 1) < lo;
		hi = 64'd2 - hi - {63'd0, borrow};
		hi2 = mul_hi(r, diff, unused);
		return hi2 + ((hi != 0) ? r : 64'd0);
	endfunction

	function automatic logic [63:0] seed(input logic [31:0] d);
		int          shift;
		logic [31:0] a1;
		logic [63:0] ent, r1;
		longint      offset, slope, prod, q;
		shift = 31;
		for (int b = 0; b < 32; b++)
			if (d[b])
				shift = 31 - b;
		a1 = d << shift;
		offset = longint'({40'd0, a1[OFFSET_BITS-1:0]}) - (longint'(1) << (OFFSET_BITS - 1)) + 1;
		ent = coeffs[a1[30 -: INDEX_WIDTH]];
		r1 = {31'd0, 1'b1, ent[31:0]};
		slope = (offset < 0) ? longint'({48'd0, ent[47:32]}) : longint'({48'd0, ent[63:48]});
		prod = slope * offset;
		q = prod >>> SLOPE_SHIFT;
		return (r1 - 64'(q)) << shift;
	endfunction

	function automatic recip_t predict_recip(input logic [31:0] d);
		recip_t      res;
		logic [63:0] r;
		if (d < 3) begin
			res.recip = 64'd0;
			res.bad = 1'b1;
			return res;
		end
		r = nr_step(seed(d), {32'd0, d});
		if (d <= step_limit)
			for (int k = 1; k < MAX_STEPS; k++)
				r = nr_step(r, {32'd0, d});
		res.recip = r;
		res.bad = 1'b0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		recip_t want;
		if (!arst_n) begin
			step_limit = 32'hFFFF_FFFF;
			pending_recips.delete();
		end else begin
			if (done) begin
				checked++;
				if (pending_recips.size() == 0) begin
					report("unexpected result", reciprocal, 64'd0);
				end else begin
					want = pending_recips.pop_front();
					if (reciprocal !== want.recip)
						report("reciprocal", reciprocal, want.recip);
					if (bad_divisor !== want.bad)
						report("bad_divisor", {63'd0, bad_divisor}, {63'd0, want.bad});
				end
			end
			if (start && !busy) begin
				if (action == ACT_WRITE)
					coeffs[entry_index[INDEX_WIDTH-1:0]] =
						{entry_slope_high, entry_slope_low, entry_base};
				else
					pending_recips.push_back(predict_recip(divisor));
			end
			if (psel && penable && pwrite && pready && paddr == REG_LIMIT_ADDR)
				step_limit = pwdata;
		end
	end
endmodule

/* verif/tb_reciprocal_table_newton_raphson.sv */
// Testbench top for the reciprocal unit: drives table writes, divisors and the
// step-limit register, and gives the verdict. Depends on rtnr_pkg, rtnr_checker
// and the block.
`timescale 1ns / 1ps
module tb_reciprocal_table_newton_raphson;
	import rtnr_pkg::*;

	localparam int LATENCY = 4 + 4 * MAX_STEPS;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        action = ACT_WRITE;
	logic [6:0]  entry_index = '0;
	logic [31:0] entry_base = '0;
	logic [15:0] entry_slope_low = '0;
	logic [15:0] entry_slope_high = '0;
	logic [31:0] divisor = '0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic        busy, done, bad_divisor, pready;
	logic [63:0] reciprocal;
	logic [31:0] prdata;
	int          mismatches, outstanding, checked;

	logic        seg_written [TABLE_DEPTH];
	int          items_sent = 0;
	bit          no_gaps = 0;

	always #1 clk = ~clk;

	reciprocal_table_newton_raphson u_top (.*);

	rtnr_checker u_checker (.*);

	initial begin
		#2_000_000;
		$display("timeout");
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int seg_of(input logic [31:0] d);
		int shift;
		shift = 31;
		for (int b = 0; b < 32; b++)
			if (d[b])
				shift = 31 - b;
		return int'((d << shift) >> OFFSET_BITS) & (TABLE_DEPTH - 1);
	endfunction

	task automatic idle_gap();
		int n, roll;
		roll = $urandom_range(0, 99);
		if (no_gaps || roll < 65)
			n = 0;
		else if (roll < 95)
			n = $urandom_range(1, 3);
		else
			n = $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic send(input logic act, input logic [6:0] idx, input logic [31:0] base,
			input logic [15:0] s_lo, input logic [15:0] s_hi, input logic [31:0] d);
		start <= 1'b1;
		action <= act;
		entry_index <= idx;
		entry_base <= base;
		entry_slope_low <= s_lo;
		entry_slope_high <= s_hi;
		divisor <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (act == ACT_WRITE)
			seg_written[idx[INDEX_WIDTH-1:0]] = 1'b1;
		items_sent++;
		idle_gap();
	endtask

	task automatic compute(input logic [31:0] d);
		send(ACT_COMPUTE, 7'($urandom), $urandom, 16'($urandom), 16'($urandom), d);
	endtask

	task automatic drain();
		int guard;
		start <= 1'b0;
		guard = 0;
		while (outstanding != 0 && guard < 10_000) begin
			@(posedge clk);
			guard++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_divisor(input logic [31:0] limit);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return $urandom_range(0, 10);
		else if (roll < 20)
			return (32'd1 << $urandom_range(1, 31)) + $urandom_range(0, 2) - 1;
		else if (roll < 30)
			return limit + $urandom_range(0, 2) - 1;
		else if (roll < 45)
			return $urandom >> $urandom_range(0, 31);
		else
			return $urandom;
	endfunction

	task automatic random_items(input int count, input logic [31:0] limit);
		logic [31:0] d;
		logic [15:0] s_lo, s_hi;
		int          idx;
		for (int i = 0; i < count; i++) begin
			if (i % 100 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			d = pick_divisor(limit);
			idx = seg_of(d);
			if ($urandom_range(0, 99) < 15 || (d >= 3 && !seg_written[idx])) begin
				// table write; for a still-empty lookup segment it targets that index, bit 6 possibly set at random
				s_lo = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
				s_hi = ($urandom_range(0, 9) == 0) ? 16'h0000 : 16'($urandom);
				if (d >= 3 && !seg_written[idx])
					send(ACT_WRITE, {$urandom_range(0, 1) ? 1'b1 : 1'b0, 6'(idx)} & 7'h7F
						| 7'(idx), $urandom, s_lo, s_hi, 32'd0);
				else
					send(ACT_WRITE, 7'($urandom), $urandom, s_lo, s_hi, $urandom);
			end else begin
				compute(d);
			end
		end
	endtask

	initial begin
		logic [31:0] limits [5];
		for (int i = 0; i < TABLE_DEPTH; i++)
			seg_written[i] = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: table extremes, small divisors, both sides of the midpoint
		send(ACT_WRITE, 7'h00, 32'h0000_0000, 16'hFFFF, 16'h0000, 32'h0);
		send(ACT_WRITE, 7'h7F, 32'hFFFF_FFFF, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
		send(ACT_WRITE, 7'h40, 32'h5555_5555, 16'h1234, 16'hABCD, 32'h0);
		send(ACT_WRITE, 7'h00, 32'h0000_0000, 16'h8000, 16'h7FFF, 32'h0);
		compute(32'd0);
		compute(32'd1);
		compute(32'd2);
		compute(32'd3);
		compute(32'd6);
		compute(32'hFFFF_FFFF);
		compute(32'h8000_0000);
		compute(32'h80FF_FFFF);
		compute(32'h8080_0000);
		compute(32'h807F_FFFF);
		compute(32'h807F_FFFE);
		compute(32'h8000_0001);
		compute(32'h4000_0000);
		compute(32'hC000_0000);
		compute(32'hFF80_0000);

		limits[0] = 32'hFFFF_FFFF;
		limits[1] = 32'h0000_0000;
		limits[2] = 32'h8000_0000;
		limits[3] = $urandom;
		limits[4] = 32'h0000_0003;
		for (int ph = 0; ph < 5; ph++) begin
			drain();
			reg_write(REG_LIMIT_ADDR, limits[ph]);
			// a write to an unmapped address must leave the limit alone
			if (ph == 3)
				reg_write(3'd4, 32'h0);
			random_items(325, limits[ph]);
		end
		drain();

		$display("sent %0d items over 5 step-limit settings, %0d results checked",
			items_sent, checked);
		if (mismatches == 0 && outstanding == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
